### rtl/kvc_pkg.sv
// Shared types and constants for the key/value cache store.
package kvc_pkg;

   localparam int LAYERS_DEF   = 4;
   localparam int HEADS_DEF    = 4;
   localparam int MAX_POS_DEF  = 128;
   localparam int VEC_LEN_DEF  = 64;

   localparam logic [7:0] MAX_LEN_RESET = 8'd128;
   localparam int         WORD_W        = 32;

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_OVERFLOW = 2'd1,
      STAT_OFFSET   = 2'd2
   } status_type;

   typedef enum logic {
      CTL_CLEAR = 1'b0,
      CTL_RUN   = 1'b1
   } ctl_state_type;

   typedef struct packed {
      mode_type    mode;
      logic [1:0]  layer;
      logic [1:0]  head;
      logic [6:0]  position;
      logic [5:0]  dim_index;
      logic [7:0]  block_len;
      logic        last_element;
      logic [31:0] key_word;
      logic [31:0] value_word;
   } req_type;

   typedef struct packed {
      logic [31:0] key_out;
      logic [31:0] value_out;
      logic [7:0]  layer_len;
      status_type  status;
   } rsp_type;

endpackage

### rtl/kv_cache_store.sv
// Top level of the key/value cache store: control, length table and element RAM.
//
// Usage
//   Input items arrive on req_data and are taken at a rising edge where start
//   is high and busy is low. Modes: write one key/value element of an append
//   block, read one element, clear a layer length, query a layer length.
//   Each item gives exactly one result item on rsp_data, marked by rsp_valid
//   for one cycle, in the cycle after the item is taken.
//   The result port has no back-pressure: the receiver must take every item.
//   Throughput: one item per cycle once the store is ready; reads and writes
//   use the single RAM port in the cycle they are taken, and layer lengths
//   sit in flip-flops, so back-to-back items see each other's updates.
//   Reset: layer lengths clear and max_len returns to 128 at once; then a
//   clearing pass writes zero to every element, one word a cycle, covering
//   all LAYERS*HEADS*MAX_POS*VEC_LEN words (131072 with the defaults). busy is
//   high throughout. csr_we/csr_wdata set max_len at any time; write it only
//   while no item is in flight.
module kv_cache_store #(
   parameter int LAYERS   = kvc_pkg::LAYERS_DEF,
   parameter int HEADS    = kvc_pkg::HEADS_DEF,
   parameter int MAX_POS  = kvc_pkg::MAX_POS_DEF,
   parameter int VEC_LEN  = kvc_pkg::VEC_LEN_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  kvc_pkg::req_type req_data,
   output logic            rsp_valid,
   output kvc_pkg::rsp_type rsp_data,
   input  logic            csr_we,
   input  logic [7:0]      csr_wdata
);

   import kvc_pkg::*;

   localparam longint DEPTH = longint'(LAYERS) * longint'(HEADS) *
                              longint'(MAX_POS) * longint'(VEC_LEN);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LY_W   = (LAYERS > 1) ? $clog2(LAYERS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   // position cap as seen by an 8-bit length
   localparam logic [7:0] POS_CAP = (MAX_POS > 255) ? 8'd255 : 8'(MAX_POS);

   // control state
   ctl_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [7:0]        max_len_ff, max_len_in;
   logic [7:0]        fill_ff [LAYERS];

   // result stage
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rd_ok_ff, rd_ok_in;
   logic [7:0] layer_len_ff, layer_len_in;
   status_type status_ff, status_in;

   // decode of the incoming item
   logic             accept;
   logic             clearing;
   logic             layer_ok, elem_ok, rd_ok, wr_ok;
   logic [LY_W-1:0]  ly_idx;
   logic [7:0]       past, limit, new_len;
   logic [8:0]       sum_len;
   logic             overflow, offs_bad;
   logic [8:0]       flat_pos;
   logic [ADDR_W-1:0] item_addr, ram_addr;
   logic             ram_wr, ram_rd;
   logic [63:0]      ram_wdata, ram_rdata;

   assign accept   = start && !busy;
   assign ly_idx   = LY_W'(req_data.layer);
   assign layer_ok = 32'(req_data.layer) < LAYERS;
   assign elem_ok  = layer_ok && (32'(req_data.head) < HEADS) &&
                     (32'(req_data.dim_index) < VEC_LEN);
   assign rd_ok    = elem_ok && (32'(req_data.position) < MAX_POS);
   assign past     = layer_ok ? fill_ff[ly_idx] : 8'd0;
   assign limit    = (max_len_ff < POS_CAP) ? max_len_ff : POS_CAP;
   assign sum_len  = {1'b0, past} + {1'b0, req_data.block_len};
   assign overflow = sum_len > {1'b0, limit};
   assign offs_bad = {1'b0, req_data.position} >= req_data.block_len;
   assign wr_ok    = (req_data.mode == MODE_WRITE) && elem_ok && !overflow && !offs_bad;

   // write lands at the layer length plus the offset; read at the absolute position
   assign flat_pos = (req_data.mode == MODE_WRITE) ?
                     ({1'b0, past} + {2'b00, req_data.position}) :
                     {2'b00, req_data.position};

   assign item_addr = ((ADDR_W'(req_data.layer) * ADDR_W'(HEADS) + ADDR_W'(req_data.head))
                       * ADDR_W'(MAX_POS) + ADDR_W'(flat_pos)) * ADDR_W'(VEC_LEN)
                      + ADDR_W'(req_data.dim_index);

   // the clearing pass owns the RAM port until it finishes
   assign ram_addr  = clearing ? clr_addr_ff : item_addr;
   assign ram_wr    = clearing || (accept && wr_ok);
   assign ram_rd    = accept && (req_data.mode == MODE_READ) && rd_ok;
   assign ram_wdata = clearing ? 64'd0 : {req_data.key_word, req_data.value_word};

   kvc_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (64),
      .DEPTH  (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .rd_en   (ram_rd),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = CTL_RUN;
            end
         end
         CTL_RUN:   state_in = CTL_RUN;
         default:   state_in = CTL_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      clearing = 1'b0;
      case (state_ff)
         CTL_CLEAR: clearing = 1'b1;
         CTL_RUN:   clearing = 1'b0;
         default:   clearing = 1'b1;
      endcase
   end

   assign busy = clearing;

   // advance the sweep address
   assign clr_addr_in = clearing ? clr_addr_ff + ADDR_W'(1) : clr_addr_ff;
   assign max_len_in  = csr_we ? csr_wdata : max_len_ff;

   // length after this item, and its status
   always_comb begin
      new_len   = past;
      status_in = STAT_OK;
      case (req_data.mode)
         MODE_WRITE: begin
            if (!elem_ok || overflow) begin
               status_in = STAT_OVERFLOW;
            end else if (offs_bad) begin
               status_in = STAT_OFFSET;
            end else if (req_data.last_element) begin
               new_len = sum_len[7:0];
            end
         end
         MODE_READ: begin
            if (!rd_ok) begin
               status_in = STAT_OVERFLOW;
            end
         end
         MODE_CLEAR: begin
            new_len = 8'd0;
            if (!layer_ok) begin
               status_in = STAT_OVERFLOW;
            end
         end
         MODE_QUERY: begin
            if (!layer_ok) begin
               status_in = STAT_OVERFLOW;
            end
         end
         default: status_in = STAT_OVERFLOW;
      endcase
   end

   assign rsp_valid_in = accept;
   assign rd_ok_in     = (req_data.mode == MODE_READ) && rd_ok;
   assign layer_len_in = layer_ok ? new_len : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_CLEAR;
         clr_addr_ff  <= '0;
         max_len_ff   <= MAX_LEN_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LAYERS; i++) begin
            fill_ff[i] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         max_len_ff   <= max_len_in;
         rsp_valid_ff <= rsp_valid_in;
         // commit the layer length on the item that changes it
         if (accept && layer_ok) begin
            fill_ff[ly_idx] <= new_len;
         end
      end
   end

   // result payload; no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ok_ff     <= rd_ok_in;
         layer_len_ff <= layer_len_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data.key_out   = rd_ok_ff ? ram_rdata[63:32] : 32'd0;
   assign rsp_data.value_out = rd_ok_ff ? ram_rdata[31:0] : 32'd0;
   assign rsp_data.layer_len = layer_len_ff;
   assign rsp_data.status    = status_ff;

endmodule

### rtl/kvc_ram.sv
// Single-port synchronous RAM with registered read data.
module kvc_ram #(
   parameter int ADDR_W = 17,
   parameter int DATA_W = 64,
   parameter longint DEPTH = 131072
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   // hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
